// File: hdl/pia_pkg.sv
// Package for the process identifier allocator.
// Holds table sizes, field widths, codes and the structs shared by the modules.
// No dependencies.
`default_nettype none

package pia_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int ID_LIMIT      = 128;

   localparam int SLOT_W   = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int PID_W    = $clog2(ID_LIMIT);
   localparam int ID_W     = $clog2(ID_LIMIT + 1);
   localparam int STATUS_W = 2;

   localparam int FULL_COUNT = (TABLE_ENTRIES < ID_LIMIT - 1) ? TABLE_ENTRIES : ID_LIMIT - 1;

   localparam logic [ID_W-1:0]    ID_TOP     = ID_W'(ID_LIMIT);
   localparam logic [ID_W-1:0]    ID_FIRST   = ID_W'(1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_ENTRIES - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(FULL_COUNT);

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_LIVE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [PID_W-1:0]  wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] live_count;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// File: hdl/pia_if.sv
// Request and response channel interfaces of the process identifier allocator.
// Depends on pia_pkg for the field widths.
`default_nettype none

interface pia_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [pia_pkg::PID_W-1:0]  release_id;

   modport source (output valid, output mode, output release_id, input ready);
   modport sink   (input valid, input mode, input release_id, output ready);
endinterface

interface pia_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pia_pkg::PID_W-1:0]    given_id;
   logic [pia_pkg::STATUS_W-1:0] status;

   modport source (output valid, output given_id, output status, input ready);
   modport sink   (input valid, input given_id, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/pia_id_ram.sv
// Live identifier table: one write port, one registered read port.
// Depends on pia_pkg.
`default_nettype none

module pia_id_ram (
   input  wire logic                       clock,
   input  wire pia_pkg::ram_req_type       ram_req,
   output logic [pia_pkg::PID_W-1:0]       rd_data
);
   import pia_pkg::*;

   logic [PID_W-1:0] mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data <= mem[ram_req.rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/pia_ctrl.sv
// Allocator control: request decode, table walk with rescan, commit and response register.
// Depends on pia_pkg, pia_if and the read data of pia_id_ram.
`default_nettype none

module pia_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pia_req_if.sink                    req_chan,
   pia_rsp_if.source                  rsp_chan,
   output pia_pkg::ram_req_type       ram_req,
   input  wire logic [pia_pkg::PID_W-1:0] ram_rd_data,
   output pia_pkg::ctrl_stat_type     stat
);
   import pia_pkg::*;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [PID_W-1:0]   rid_ff, rid_in;
   logic               scan_ff, scan_in;
   logic               full_ff, full_in;
   logic [ID_W-1:0]    lg_ff, lg_in;
   logic [ID_W-1:0]    bound_ff, bound_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  issue_idx_ff, issue_idx_in;
   logic               issue_more_ff, issue_more_in;
   logic               p_valid_ff, p_valid_in;
   logic [SLOT_W-1:0]  p_idx_ff, p_idx_in;
   logic               p_live_ff, p_live_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PID_W-1:0]   rsp_given_ff, rsp_given_in;
   status_type         rsp_status_ff, rsp_status_in;

   always_comb begin
      logic [ID_W:0]   lg_inc;
      logic [ID_W-1:0] p_ext;
      logic            restart;
      logic            done;

      lg_inc  = {1'b0, lg_ff} + (ID_W+1)'(1);
      p_ext   = ID_W'(ram_rd_data);
      restart = 1'b0;
      done    = 1'b0;

      state_in      = state_ff;
      mode_in       = mode_ff;
      rid_in        = rid_ff;
      scan_in       = scan_ff;
      full_in       = full_ff;
      lg_in         = lg_ff;
      bound_in      = bound_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      issue_idx_in  = issue_idx_ff;
      issue_more_in = issue_more_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      p_live_in     = p_live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_given_in  = rsp_given_ff;
      rsp_status_in = rsp_status_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = slot_ff;
      ram_req.wr_data = PID_W'(lg_ff);
      ram_req.rd_addr = issue_idx_ff;

      req_chan.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in       = mode_type'(req_chan.mode);
               rid_in        = req_chan.release_id;
               found_in      = 1'b0;
               scan_in       = 1'b0;
               full_in       = 1'b0;
               issue_idx_in  = '0;
               issue_more_in = 1'b1;
               if (mode_type'(req_chan.mode) == MODE_ALLOC) begin
                  if (count_ff >= COUNT_FULL) begin
                     full_in  = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     if (lg_inc >= {1'b0, ID_TOP}) begin
                        lg_in    = ID_FIRST;
                        scan_in  = 1'b1;
                        bound_in = ID_TOP;
                     end else if (lg_inc >= {1'b0, bound_ff}) begin
                        lg_in    = lg_inc[ID_W-1:0];
                        scan_in  = 1'b1;
                        bound_in = ID_TOP;
                     end else begin
                        lg_in = lg_inc[ID_W-1:0];
                     end
                     state_in = ST_SCAN;
                  end
               end else if (req_chan.release_id == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue_more_ff) begin
               p_valid_in    = 1'b1;
               p_idx_in      = issue_idx_ff;
               p_live_in     = valid_ff[issue_idx_ff];
               issue_idx_in  = issue_idx_ff + SLOT_W'(1);
               issue_more_in = (issue_idx_ff != SLOT_LAST);
            end
            if (p_valid_ff) begin
               if (mode_ff == MODE_ALLOC) begin
                  if (!p_live_ff && !found_ff) begin
                     found_in = 1'b1;
                     slot_in  = p_idx_ff;
                  end
                  if (scan_ff && p_live_ff) begin
                     if (p_ext == lg_ff) begin
                        if (lg_inc >= {1'b0, bound_ff}) begin
                           restart  = 1'b1;
                           bound_in = ID_TOP;
                           lg_in    = (lg_inc >= {1'b0, ID_TOP}) ? ID_FIRST : lg_inc[ID_W-1:0];
                        end else begin
                           lg_in = lg_inc[ID_W-1:0];
                        end
                     end else if (p_ext > lg_ff && bound_ff > p_ext) begin
                        bound_in = p_ext;
                     end
                  end
                  done = !restart && ((p_idx_ff == SLOT_LAST) || (!scan_ff && found_in));
               end else begin
                  if (p_live_ff && ram_rd_data == rid_ff) begin
                     found_in = 1'b1;
                     slot_in  = p_idx_ff;
                     done     = 1'b1;
                  end else begin
                     done = (p_idx_ff == SLOT_LAST);
                  end
               end
               if (restart) begin
                  issue_idx_in  = '0;
                  issue_more_in = 1'b1;
                  p_valid_in    = 1'b0;
               end
               if (done) begin
                  state_in      = ST_FINISH;
                  issue_more_in = 1'b0;
                  p_valid_in    = 1'b0;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (mode_ff == MODE_ALLOC) begin
                  if (full_ff) begin
                     rsp_given_in  = '0;
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ram_req.wr_en     = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     count_in          = count_ff + COUNT_W'(1);
                     rsp_given_in      = PID_W'(lg_ff);
                     rsp_status_in     = STATUS_OK;
                  end
               end else if (found_ff) begin
                  valid_in[slot_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_W'(1);
                  end
                  rsp_given_in  = rid_ff;
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_given_in  = '0;
                  rsp_status_in = STATUS_NOT_LIVE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         lg_ff         <= ID_TOP;
         bound_ff      <= ID_TOP;
         count_ff      <= '0;
         issue_more_ff <= 1'b0;
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         lg_ff         <= lg_in;
         bound_ff      <= bound_in;
         count_ff      <= count_in;
         issue_more_ff <= issue_more_in;
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      rid_ff        <= rid_in;
      scan_ff       <= scan_in;
      full_ff       <= full_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      issue_idx_ff  <= issue_idx_in;
      p_idx_ff      <= p_idx_in;
      p_live_ff     <= p_live_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.given_id = rsp_given_ff;
   assign rsp_chan.status   = rsp_status_ff;

   assign stat.busy       = (state_ff != ST_IDLE);
   assign stat.live_count = count_ff;

endmodule

`default_nettype wire

// File: hdl/process_id_allocator.sv
// Top level of the process identifier allocator: control and live identifier table.
// Depends on pia_pkg, pia_if, pia_id_ram and pia_ctrl.
//
//   channel    direction  handshake          payload
//   req_chan   in         valid / ready      mode, release_id
//   rsp_chan   out        valid / ready      given_id, status
//
// A request is taken only while the block is idle; one response per request.
// Allocate without rescan: the walk stops at the lowest free slot. Allocate with rescan:
// the walk covers the whole table through the single read port, one extra pass per rescan
// restart. Release stops at the matching slot; full or release of zero: no walk.
// Reset clears the live flags at once: no clearing pass. A stalled response holds only
// the commit step; the next request is taken while the previous response waits.
`default_nettype none

module process_id_allocator (
   input  wire logic clock,
   input  wire logic reset,
   pia_req_if.sink   req_chan,
   pia_rsp_if.source rsp_chan
);
   import pia_pkg::*;

   ram_req_type        ram_req;
   logic [PID_W-1:0]   ram_rd_data;
   ctrl_stat_type      stat;

   pia_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .stat        (stat)
   );

   pia_id_ram u_id_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stat.busy)
      else $error("block not busy after taking a request");

   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |-> (rsp_chan.given_id == '0))
      else $error("error response carries a nonzero identifier");

   a_ok_gives_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_OK) |-> (rsp_chan.given_id != '0))
      else $error("ok response carries identifier zero");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      stat.live_count <= COUNT_FULL)
      else $error("live count beyond table capacity");
`endif

endmodule

`default_nettype wire

// File: tb/tb_process_id_allocator.sv
`timescale 1ns / 1ps
// Testbench for process_id_allocator: directed and random allocate and release requests,
// each response checked against a behavioral model of the live identifier table.
// Depends on pia_pkg, pia_if and the process_id_allocator RTL.

module tb_process_id_allocator;
   import pia_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int BATCHES     = 90;
   localparam int BATCH_SIZE  = 20;
   localparam int MAX_IDLE    = 11;

   typedef struct {
      mode_type         mode;
      logic [PID_W-1:0] rid;
   } pid_request_type;

   typedef struct {
      logic [PID_W-1:0] id;
      status_type       st;
   } grant_type;

   logic clock;
   logic reset;

   pia_req_if req_chan ();
   pia_rsp_if rsp_chan ();

   process_id_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // identifier table model
   logic [PID_W-1:0] slot_id   [TABLE_ENTRIES];
   bit               slot_live [TABLE_ENTRIES];
   int unsigned      last_id;
   int unsigned      scan_bound;
   int unsigned      live_total;

   pid_request_type pending_requests [$];
   grant_type       grants_due [$];
   pid_request_type current;

   int unsigned issued;
   int unsigned answered;
   int unsigned errors;
   int unsigned cycles;
   bit          idle_on;
   bit          hold_req;
   bit          req_taken;
   bit          rsp_taken;
   bit          offering;
   bit          gap_drawn;
   bit          stall_drawn;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void advance_last_id();
      bit rescan;
      bit restart;
      int unsigned held;
      rescan = 1'b0;
      last_id++;
      if (last_id >= ID_LIMIT) begin
         last_id = 1;
         rescan  = 1'b1;
      end else if (last_id >= scan_bound) begin
         rescan = 1'b1;
      end
      if (!rescan)
         return;
      scan_bound = ID_LIMIT;
      do begin
         restart = 1'b0;
         for (int s = 0; s < TABLE_ENTRIES && !restart; s++) begin
            if (!slot_live[s])
               continue;
            held = slot_id[s];
            if (held == last_id) begin
               last_id++;
               if (last_id >= scan_bound) begin
                  if (last_id >= ID_LIMIT)
                     last_id = 1;
                  scan_bound = ID_LIMIT;
                  restart    = 1'b1;
               end
            end else if (held > last_id && scan_bound > held) begin
               scan_bound = held;
            end
         end
      end while (restart);
   endfunction

   function automatic grant_type grant_for(input mode_type mode, input logic [PID_W-1:0] rid);
      grant_type g;
      g.id = '0;
      g.st = STATUS_OK;
      if (mode == MODE_ALLOC) begin
         if (live_total >= TABLE_ENTRIES || live_total >= ID_LIMIT - 1) begin
            g.st = STATUS_FULL;
         end else begin
            advance_last_id();
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
               if (!slot_live[s]) begin
                  slot_live[s] = 1'b1;
                  slot_id[s]   = PID_W'(last_id);
                  live_total++;
                  break;
               end
            end
            g.id = PID_W'(last_id);
         end
      end else begin
         g.st = STATUS_NOT_LIVE;
         for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (slot_live[s] && slot_id[s] == rid && rid != 0) begin
               slot_live[s] = 1'b0;
               if (live_total > 0)
                  live_total--;
               g.id = rid;
               g.st = STATUS_OK;
               break;
            end
         end
      end
      return g;
   endfunction

   function automatic logic [PID_W-1:0] pick_release_id();
      logic [PID_W-1:0] held [$];
      for (int s = 0; s < TABLE_ENTRIES; s++)
         if (slot_live[s])
            held.push_back(slot_id[s]);
      if (held.size() == 0 || $urandom_range(0, 4) == 0)
         return PID_W'($urandom_range(0, ID_LIMIT - 1));
      return held[$urandom_range(0, held.size() - 1)];
   endfunction

   task automatic queue_request(input mode_type mode, input logic [PID_W-1:0] rid);
      pid_request_type r;
      r.mode = mode;
      r.rid  = rid;
      pending_requests.push_back(r);
      issued++;
   endtask

   task automatic wait_answers();
      while (answered != issued)
         @(negedge clock);
   endtask

   task automatic flag_error(input string text);
      errors++;
      if (errors <= 10)
         $display("%s", text);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset !== 1'b0) begin
         req_chan.valid = 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            offering  = 1'b0;
         end
         if (!offering && pending_requests.size() != 0) begin
            if (!gap_drawn) begin
               gap_left  = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
               gap_drawn = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               current   = pending_requests.pop_front();
               offering  = 1'b1;
               gap_drawn = 1'b0;
            end
         end
         req_chan.valid      = offering;
         req_chan.mode       = current.mode;
         req_chan.release_id = current.rid;
      end
   end

   // response ready, with random stalls and the long hold
   always @(negedge clock) begin
      if (reset !== 1'b0) begin
         rsp_chan.ready = 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken   = 1'b0;
            stall_drawn = 1'b0;
         end
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (!stall_drawn) begin
            stall_left  = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            stall_drawn = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // monitor: check responses, then predict for newly accepted requests
   always @(posedge clock) begin
      grant_type want;
      if (reset === 1'b0) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken = 1'b1;
            if (grants_due.size() == 0) begin
               flag_error($sformatf("unexpected response: id %0d status %0d",
                                    rsp_chan.given_id, rsp_chan.status));
            end else begin
               want = grants_due.pop_front();
               answered++;
               if (rsp_chan.given_id !== want.id || rsp_chan.status !== want.st)
                  flag_error($sformatf("mismatch: expected id %0d status %s, got id %0d status %0d",
                                       want.id, want.st.name(), rsp_chan.given_id,
                                       rsp_chan.status));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            grants_due.push_back(grant_for(mode_type'(req_chan.mode), req_chan.release_id));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[process_id_allocator] ERROR");
         $finish;
      end
   end

   initial begin
      int alloc_pct;
      int count;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_ALLOC;
      req_chan.release_id = '0;
      rsp_chan.ready      = 1'b0;
      current.mode        = MODE_ALLOC;
      current.rid         = '0;
      for (int s = 0; s < TABLE_ENTRIES; s++) begin
         slot_id[s]   = '0;
         slot_live[s] = 1'b0;
      end
      last_id    = ID_LIMIT;
      scan_bound = ID_LIMIT;
      live_total = 0;
      idle_on    = 1'b1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: basic allocation, double release, zero and top identifiers
      queue_request(MODE_ALLOC, '0);
      queue_request(MODE_ALLOC, '1);
      queue_request(MODE_ALLOC, PID_W'(7'h55));
      queue_request(MODE_RELEASE, PID_W'(2));
      queue_request(MODE_RELEASE, PID_W'(2));
      queue_request(MODE_RELEASE, '0);
      queue_request(MODE_RELEASE, PID_W'(ID_LIMIT - 1));
      queue_request(MODE_ALLOC, PID_W'(7'h2a));
      queue_request(MODE_RELEASE, PID_W'(1));
      queue_request(MODE_ALLOC, '0);
      queue_request(MODE_RELEASE, PID_W'(4));
      queue_request(MODE_RELEASE, PID_W'(3));
      queue_request(MODE_RELEASE, PID_W'(5));
      queue_request(MODE_RELEASE, PID_W'(5));
      wait_answers();

      // random batches; the sender drains fully between batches
      for (int b = 0; b < BATCHES; b++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (b == 3 || b == 60)
            hold_req = 1'b1;
         case ($urandom_range(0, 2))
            0:       alloc_pct = 90;
            1:       alloc_pct = 25;
            default: alloc_pct = 55;
         endcase
         count = BATCH_SIZE;
         if (b == 1) begin
            alloc_pct = 100;
            count     = TABLE_ENTRIES + 6;
         end
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < alloc_pct)
               queue_request(MODE_ALLOC, PID_W'($urandom_range(0, ID_LIMIT - 1)));
            else
               queue_request(MODE_RELEASE, pick_release_id());
         end
         wait_answers();
      end

      repeat (2 * (TABLE_ENTRIES + 3)) @(posedge clock);
      if (errors == 0 && grants_due.size() == 0)
         $display("[process_id_allocator] OK");
      else
         $display("[process_id_allocator] ERROR");
      $finish;
   end

endmodule
